@@ src/fevad_pkg.sv @@
// Shared types and constants of the frame energy voice activity detector.
// Used by fevad_root_engine and frame_energy_voice_activity_detector.
// Depends on nothing.
package fevad_pkg;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_DURATION_MS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TIMEOUT_MS = 2'd2;

	// Register widths and reset values.
	localparam int THR_W = 16;
	localparam int DUR_W = 10;
	localparam int TMO_W = 16;
	localparam logic [THR_W-1:0] THR_RESET = 16'd200;
	localparam logic [DUR_W-1:0] DUR_RESET = 10'd40;
	localparam logic [TMO_W-1:0] TMO_RESET = 16'd1500;

	// Sample path.
	localparam int SAMPLE_W = 16;
	localparam int SQUARE_W = 32;

	// Square root: a radicand of 32 bits gives a root of 16 bits.
	localparam int RAD_W      = 32;
	localparam int ROOT_W     = 16;
	localparam int SREM_W     = 18;
	localparam int SQRT_STEPS = 16;

	// Silence timer.
	localparam int SIL_W = 17;

	// End reason codes.
	localparam int REASON_W = 2;
	localparam logic [REASON_W-1:0] REASON_CONTINUE = 2'd0;
	localparam logic [REASON_W-1:0] REASON_TIMEOUT  = 2'd1;
	localparam logic [REASON_W-1:0] REASON_STOP     = 2'd2;

	// Main sequencer.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SQUARE,
		S_ACCUM,
		S_START,
		S_ROOT,
		S_JUDGE
	} top_state_t;

	// Divide and square root engine.
	typedef enum logic [1:0] {
		E_IDLE,
		E_DIV,
		E_SQRT
	} eng_state_t;

endpackage

@@ src/fevad_cmpsub.sv @@
// Shared compare and subtract unit of the frame energy detector.
// Used by fevad_root_engine for both division and square root steps.
// Depends on nothing.
module fevad_cmpsub #(
	parameter int W = 20
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         ge,
	output logic [W-1:0] diff
);

	assign ge   = (a >= b);
	assign diff = a - b;

endmodule

@@ src/fevad_root_engine.sv @@
// Iterative engine: restoring division of the frame energy by the sample
// count, then a digit-by-digit square root of the quotient.
// Depends on fevad_pkg and fevad_cmpsub.
module fevad_root_engine #(
	parameter int SUM_W = 43,
	parameter int CNT_W = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [SUM_W-1:0]          dividend,
	input  logic [CNT_W-1:0]          divisor,
	output logic                      done,
	output logic [fevad_pkg::ROOT_W-1:0] root
);

	localparam int SQ_SHIFT_W = fevad_pkg::SREM_W + 2;
	localparam int ALU_W      = (CNT_W + 1 > SQ_SHIFT_W) ? CNT_W + 1 : SQ_SHIFT_W;
	localparam int STEP_W     = $clog2(SUM_W);

	fevad_pkg::eng_state_t state_q, state_d;

	logic [STEP_W-1:0]                   cnt_q;
	logic                                done_q;
	logic [SUM_W-1:0]                    quot_q;
	logic [CNT_W-1:0]                    rem_q;
	logic [CNT_W-1:0]                    div_q;
	logic [fevad_pkg::RAD_W-1:0]         rad_q;
	logic [fevad_pkg::SREM_W-1:0]        srem_q;
	logic [fevad_pkg::ROOT_W-1:0]        root_q;

	logic [CNT_W:0]                      div_shift;
	logic [SQ_SHIFT_W-1:0]               sq_shift;
	logic [fevad_pkg::ROOT_W+1:0]        trial;
	logic [ALU_W-1:0]                    alu_a, alu_b, alu_diff;
	logic                                alu_ge;
	logic [SUM_W-1:0]                    quot_next;
	logic                                last;

	assign div_shift = {rem_q, quot_q[SUM_W-1]};
	assign sq_shift  = {srem_q, rad_q[fevad_pkg::RAD_W-1 -: 2]};
	assign trial     = {root_q, 2'b01};
	assign quot_next = {quot_q[SUM_W-2:0], alu_ge};

	always_comb begin
		if (state_q == fevad_pkg::E_DIV) begin
			alu_a = ALU_W'(div_shift);
			alu_b = ALU_W'(div_q);
		end else begin
			alu_a = ALU_W'(sq_shift);
			alu_b = ALU_W'(trial);
		end
	end

	fevad_cmpsub #(
		.W(ALU_W)
	) u_cmpsub (
		.a   (alu_a),
		.b   (alu_b),
		.ge  (alu_ge),
		.diff(alu_diff)
	);

	always_comb begin
		case (state_q)
			fevad_pkg::E_DIV:  last = (cnt_q == STEP_W'(SUM_W - 1));
			fevad_pkg::E_SQRT: last = (cnt_q == STEP_W'(fevad_pkg::SQRT_STEPS - 1));
			default:           last = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fevad_pkg::E_IDLE: if (start) state_d = fevad_pkg::E_DIV;
			fevad_pkg::E_DIV:  if (last) state_d = fevad_pkg::E_SQRT;
			fevad_pkg::E_SQRT: if (last) state_d = fevad_pkg::E_IDLE;
			default:           state_d = fevad_pkg::E_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fevad_pkg::E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (state_q == fevad_pkg::E_IDLE || state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
			done_q <= (state_q == fevad_pkg::E_SQRT) && last;
		end
	end

	// Division keeps the quotient in the shifting dividend register.
	always_ff @(posedge clk) begin
		case (state_q)
			fevad_pkg::E_IDLE: begin
				if (start) begin
					quot_q <= dividend;
					div_q  <= divisor;
					rem_q  <= '0;
				end
			end
			fevad_pkg::E_DIV: begin
				quot_q <= quot_next;
				rem_q  <= alu_ge ? alu_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
				if (last) begin
					rad_q  <= quot_next[fevad_pkg::RAD_W-1:0];
					srem_q <= '0;
					root_q <= '0;
				end
			end
			fevad_pkg::E_SQRT: begin
				rad_q  <= {rad_q[fevad_pkg::RAD_W-3:0], 2'b00};
				srem_q <= alu_ge ? alu_diff[fevad_pkg::SREM_W-1:0]
				                 : sq_shift[fevad_pkg::SREM_W-1:0];
				root_q <= {root_q[fevad_pkg::ROOT_W-2:0], alu_ge};
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ src/frame_energy_voice_activity_detector.sv @@
// A sample that does not end a frame passes the accept, square and accumulate states,
// and no new beat is taken before it is back in idle. A frame-end beat also runs SUM_W
// division steps and 16 root steps in the engine; its result beat is offered once the
// judge state loads the output register, and the next input beat can be taken after that.
// A stalled result still held in the output register delays both the result and that beat.
// Reset (arst_n low) clears all control and session state and loads register defaults.
//
// Top level of the frame energy voice activity detector. It holds the configuration
// registers, the squaring and accumulation path, the main sequencer, the session logic
// and the output register. Depends on fevad_pkg and fevad_root_engine.
module frame_energy_voice_activity_detector #(
	parameter int MAX_FRAME_SAMPLES = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [fevad_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fevad_pkg::CFG_DATA_W-1:0]    cfg_data,

	// Input channel.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [fevad_pkg::SAMPLE_W-1:0] sample,
	input  logic                                frame_end,
	input  logic                                stop_request,

	// Output channel.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [fevad_pkg::ROOT_W-1:0]        frame_level,
	output logic                                voiced,
	output logic [fevad_pkg::REASON_W-1:0]      end_reason
);

	// The sample count must be able to hold MAX_FRAME_SAMPLES itself. Each square is
	// at most 2^30, so the energy sum needs 31 bits above the count width.
	localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam int SUM_W = 31 + CNT_W;

	fevad_pkg::top_state_t state_q, state_d;

	// Configuration registers.
	logic [fevad_pkg::THR_W-1:0]   thr_q;
	logic [fevad_pkg::DUR_W-1:0]   dur_q;
	logic [fevad_pkg::TMO_W-1:0]   tmo_q;

	// Captured input beat.
	logic [fevad_pkg::SAMPLE_W-1:0] mag_q;
	logic                          fend_q;
	logic                          stop_q;
	logic [fevad_pkg::SQUARE_W-1:0] square_q;

	// Frame and session state.
	logic [SUM_W-1:0]              energy_q;
	logic [CNT_W-1:0]              count_q;
	logic                          speech_q;
	logic [fevad_pkg::SIL_W-1:0]   silence_q;

	// Output register.
	logic                          out_valid_q;
	logic [fevad_pkg::ROOT_W-1:0]  level_q;
	logic                          active_q;
	logic [fevad_pkg::REASON_W-1:0] reason_q;

	logic                          in_accept;
	logic [fevad_pkg::SAMPLE_W-1:0] sample_mag;
	logic                          out_free;
	logic                          load;
	logic                          eng_start;
	logic                          eng_done;
	logic [fevad_pkg::ROOT_W-1:0]  eng_root;

	logic                          is_speech;
	logic [fevad_pkg::SIL_W-1:0]   silence_sum;
	logic                          timed_out;
	logic                          speech_d;
	logic [fevad_pkg::SIL_W-1:0]   silence_d;
	logic [fevad_pkg::REASON_W-1:0] reason_d;
	logic                          active_d;

	// The block takes a beat only while the sequencer is idle.
	assign in_stall  = (state_q != fevad_pkg::S_IDLE);
	assign in_accept = in_valid && !in_stall;

	// Magnitude of the sample. The most negative sample maps to 0x8000, which is
	// still correct as an unsigned 16-bit value.
	assign sample_mag = sample[fevad_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;

	// The output register may be reloaded when it is empty or being taken.
	assign out_free  = !out_valid_q || !out_stall;
	assign load      = (state_q == fevad_pkg::S_JUDGE) && out_free;
	assign eng_start = (state_q == fevad_pkg::S_START);

	// Main sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			fevad_pkg::S_IDLE:   if (in_accept) state_d = fevad_pkg::S_SQUARE;
			fevad_pkg::S_SQUARE: state_d = fevad_pkg::S_ACCUM;
			fevad_pkg::S_ACCUM:  state_d = fend_q ? fevad_pkg::S_START : fevad_pkg::S_IDLE;
			fevad_pkg::S_START:  state_d = fevad_pkg::S_ROOT;
			fevad_pkg::S_ROOT:   if (eng_done) state_d = fevad_pkg::S_JUDGE;
			fevad_pkg::S_JUDGE:  if (out_free) state_d = fevad_pkg::S_IDLE;
			default:             state_d = fevad_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fevad_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes. Data bits above a register's width are dropped and an
	// index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= fevad_pkg::THR_RESET;
			dur_q <= fevad_pkg::DUR_RESET;
			tmo_q <= fevad_pkg::TMO_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fevad_pkg::REG_LEVEL_THRESHOLD:    thr_q <= cfg_data[fevad_pkg::THR_W-1:0];
				fevad_pkg::REG_FRAME_DURATION_MS:  dur_q <= cfg_data[fevad_pkg::DUR_W-1:0];
				fevad_pkg::REG_SILENCE_TIMEOUT_MS: tmo_q <= cfg_data[fevad_pkg::TMO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Capture of the input beat and the squaring stage.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mag_q  <= sample_mag;
			fend_q <= frame_end;
			stop_q <= stop_request;
		end
		if (state_q == fevad_pkg::S_SQUARE) begin
			square_q <= fevad_pkg::SQUARE_W'(mag_q) * fevad_pkg::SQUARE_W'(mag_q);
		end
	end

	// Accumulation. Once a frame holds MAX_FRAME_SAMPLES samples, further samples of
	// that frame are dropped, the frame-end sample included, but the frame is still
	// judged. The engine takes the sum and count in the start state, which also
	// clears them for the next frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			count_q  <= '0;
		end else if (state_q == fevad_pkg::S_ACCUM) begin
			if (count_q < CNT_W'(MAX_FRAME_SAMPLES)) begin
				energy_q <= energy_q + SUM_W'(square_q);
				count_q  <= count_q + 1'b1;
			end
		end else if (eng_start) begin
			energy_q <= '0;
			count_q  <= '0;
		end
	end

	// The sample count is never zero at a frame end, because the frame-end sample is
	// always counted unless the frame is already full.
	fevad_root_engine #(
		.SUM_W(SUM_W),
		.CNT_W(CNT_W)
	) u_root_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (eng_start),
		.dividend(energy_q),
		.divisor (count_q),
		.done    (eng_done),
		.root    (eng_root)
	);

	// Session logic. A loud frame marks speech and clears the silence timer. A quiet
	// frame after speech advances the timer, which wraps at 17 bits, and reaching the
	// timeout ends the session. A stop request ends it only if the timeout did not,
	// so a timeout wins when both happen together. The reported activity is the value
	// before an ending clears the session.
	assign is_speech   = (eng_root >= thr_q);
	assign silence_sum = silence_q + fevad_pkg::SIL_W'(dur_q);
	assign timed_out   = (silence_sum >= fevad_pkg::SIL_W'(tmo_q));

	always_comb begin
		speech_d  = speech_q;
		silence_d = silence_q;
		reason_d  = fevad_pkg::REASON_CONTINUE;
		if (is_speech) begin
			speech_d  = 1'b1;
			silence_d = '0;
		end else if (speech_q) begin
			silence_d = silence_sum;
			if (timed_out) begin
				reason_d = fevad_pkg::REASON_TIMEOUT;
			end
		end
		if (reason_d == fevad_pkg::REASON_CONTINUE && stop_q) begin
			reason_d = fevad_pkg::REASON_STOP;
		end
		active_d = speech_d;
		if (reason_d != fevad_pkg::REASON_CONTINUE) begin
			speech_d  = 1'b0;
			silence_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speech_q    <= 1'b0;
			silence_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				speech_q    <= speech_d;
				silence_q   <= silence_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			level_q  <= eng_root;
			active_q <= active_d;
			reason_q <= reason_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_level = level_q;
	assign voiced      = active_q;
	assign end_reason  = reason_q;

	// A frame never holds more samples than the limit.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAME_SAMPLES))
		else $error("sample count exceeds the frame limit");

	// The engine reports only while the sequencer waits for it.
	a_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done |-> state_q == fevad_pkg::S_ROOT)
		else $error("root engine finished outside the wait state");

	// A result is produced only for a frame-end beat.
	a_load_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> fend_q)
		else $error("result loaded for a beat that did not end a frame");

	// An ending clears the whole session.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(load && reason_d != fevad_pkg::REASON_CONTINUE) |=> (!speech_q && silence_q == '0))
		else $error("session state not cleared after an ending");

	// The frame accumulators are cleared once a frame goes to the engine.
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		eng_start |=> (energy_q == '0 && count_q == '0))
		else $error("frame accumulators not cleared at frame end");

endmodule

@@ sim/tb_frame_energy_voice_activity_detector.sv @@
// Self-checking testbench of the frame energy voice activity detector.
// Predicts each frame verdict in a small scoreboard class and checks every result beat.
// Depends on fevad_pkg and frame_energy_voice_activity_detector.
module tb_frame_energy_voice_activity_detector;

	// Timing of the run. The clock period is four time units.
	localparam int CLK_HALF        = 2;
	localparam int RESET_CYCLES    = 11;
	// Frame size limit of the instance, kept at the default of the block.
	localparam int MAX_FRAME       = 2048;
	// Quiet time after the last result, long enough for any sample beats still in
	// the squaring path.
	localparam int SETTLE_CYCLES   = 100;
	// Long receiver hold-off that backs the block up into its input.
	localparam int HOLD_OFF_CYCLES = 600;
	// No legal run goes this long without a single beat or register write.
	localparam int WATCHDOG_LIMIT  = 3000;
	// Random input beats per configuration phase.
	localparam int PHASE_ITEMS     = 120;
	// Cap on the quiet frames a generated session aims for; it may send one more.
	localparam int MAX_QUIET       = 24;

	// Register index past the end of the register list; writes to it do nothing.
	localparam logic [fevad_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// Shapes of generated frames, relative to the current level threshold.
	typedef enum logic [2:0] {
		KIND_SILENT,
		KIND_QUIET,
		KIND_EDGE,
		KIND_LOUD,
		KIND_NOISE
	} frame_kind_t;

	typedef struct packed {
		logic [fevad_pkg::ROOT_W-1:0]   level;
		logic                           active;
		logic [fevad_pkg::REASON_W-1:0] reason;
	} verdict_t;

	// Mirrors the configuration and session state of the block and keeps the
	// verdicts that are owed for frames already closed on the input side.
	class vad_scoreboard;
		logic [fevad_pkg::THR_W-1:0] level_thr;
		logic [fevad_pkg::DUR_W-1:0] quiet_step_ms;
		logic [fevad_pkg::TMO_W-1:0] hangover_ms;
		logic [42:0]                 energy_acc;
		int unsigned                 frame_samples;
		bit                          in_speech;
		logic [fevad_pkg::SIL_W-1:0] quiet_time_ms;
		verdict_t                    open_verdicts[$];
		int                          errors;

		function new();
			level_thr     = fevad_pkg::THR_RESET;
			quiet_step_ms = fevad_pkg::DUR_RESET;
			hangover_ms   = fevad_pkg::TMO_RESET;
			energy_acc    = '0;
			frame_samples = 0;
			in_speech     = 1'b0;
			quiet_time_ms = '0;
			errors        = 0;
		endfunction

		function void write_reg(logic [fevad_pkg::CFG_IDX_W-1:0] idx,
				logic [fevad_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				fevad_pkg::REG_LEVEL_THRESHOLD:    level_thr     = data[fevad_pkg::THR_W-1:0];
				fevad_pkg::REG_FRAME_DURATION_MS:  quiet_step_ms = data[fevad_pkg::DUR_W-1:0];
				fevad_pkg::REG_SILENCE_TIMEOUT_MS: hangover_ms   = data[fevad_pkg::TMO_W-1:0];
				default: ;
			endcase
		endfunction

		// Notes one accepted input beat; a frame end adds one owed verdict.
		function void take_sample(logic signed [fevad_pkg::SAMPLE_W-1:0] s, logic fe,
				logic stp);
			longint   mag;
			longint   mean;
			longint   root;
			longint   trial;
			verdict_t v;
			if (frame_samples < MAX_FRAME) begin
				mag = s;
				if (mag < 0)
					mag = -mag;
				energy_acc = energy_acc + 43'(mag * mag);
				frame_samples++;
			end
			if (!fe)
				return;
			mean = (frame_samples == 0) ? 0 : longint'(energy_acc) / longint'(frame_samples);
			// Floor square root, one result bit at a time from the top.
			root = 0;
			for (int b = fevad_pkg::ROOT_W - 1; b >= 0; b--) begin
				trial = root | (longint'(1) << b);
				if (trial * trial <= mean)
					root = trial;
			end
			energy_acc    = '0;
			frame_samples = 0;
			v.level  = root[fevad_pkg::ROOT_W-1:0];
			v.reason = fevad_pkg::REASON_CONTINUE;
			if (v.level >= level_thr) begin
				in_speech     = 1'b1;
				quiet_time_ms = '0;
			end else if (in_speech) begin
				quiet_time_ms = quiet_time_ms + fevad_pkg::SIL_W'(quiet_step_ms);
				if (quiet_time_ms >= fevad_pkg::SIL_W'(hangover_ms))
					v.reason = fevad_pkg::REASON_TIMEOUT;
			end
			if (v.reason == fevad_pkg::REASON_CONTINUE && stp)
				v.reason = fevad_pkg::REASON_STOP;
			v.active = in_speech;
			if (v.reason != fevad_pkg::REASON_CONTINUE) begin
				in_speech     = 1'b0;
				quiet_time_ms = '0;
			end
			open_verdicts.push_back(v);
		endfunction

		function void report(string field, logic [31:0] exp, logic [31:0] got);
			errors++;
			if (errors <= 60)
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp, got);
		endfunction

		function void check_verdict(logic [fevad_pkg::ROOT_W-1:0] level, logic active,
				logic [fevad_pkg::REASON_W-1:0] reason);
			verdict_t v;
			if (open_verdicts.size() == 0) begin
				errors++;
				if (errors <= 60)
					$display("%0t: result beat with no frame pending, level %0d %0d %0d",
						$time, level, active, reason);
				return;
			end
			v = open_verdicts.pop_front();
			if (level !== v.level)
				report("frame_level", 32'(v.level), 32'(level));
			if (active !== v.active)
				report("voiced", 32'(v.active), 32'(active));
			if (reason !== v.reason)
				report("end_reason", 32'(v.reason), 32'(reason));
		endfunction
	endclass

	logic                                  clk = 1'b0;
	logic                                  arst_n;
	logic                                  cfg_we;
	logic [fevad_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [fevad_pkg::CFG_DATA_W-1:0]      cfg_data;
	logic                                  in_valid;
	logic                                  in_stall;
	logic signed [fevad_pkg::SAMPLE_W-1:0] sample;
	logic                                  frame_end;
	logic                                  stop_request;
	logic                                  out_valid;
	logic                                  out_stall;
	logic [fevad_pkg::ROOT_W-1:0]          frame_level;
	logic                                  voiced;
	logic [fevad_pkg::REASON_W-1:0]        end_reason;

	vad_scoreboard board;
	int items_sent   = 0;
	int quiet_cycles = 0;
	// When set, the sender offers beats back to back with no gaps.
	bit steady       = 1'b0;
	// Set by the stimulus, cleared by the receiver once its long hold-off is over.
	bit hold_off_req = 1'b0;

	frame_energy_voice_activity_detector #(
		.MAX_FRAME_SAMPLES(MAX_FRAME)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.frame_end(frame_end),
		.stop_request(stop_request),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_level(frame_level),
		.voiced(voiced),
		.end_reason(end_reason)
	);

	always #(CLK_HALF) clk = ~clk;

	// Both channels are sampled at the rising edge, where every testbench drive
	// and every register of the block still holds its pre-edge value. The same
	// block keeps the watchdog: it counts edges at which nothing moved at all.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_stall === 1'b0)
				board.take_sample(sample, frame_end, stop_request);
			if (out_valid === 1'b1 && out_stall == 1'b0)
				board.check_verdict(frame_level, voiced, end_reason);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Receiver. Stall runs of random length: mostly short, now and then a long
	// one, and some long stretches with no stall at all. On request it holds off
	// for a long time so that the block fills and stalls its input.
	initial begin
		int r;
		int run;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					out_stall <= 1'b0;
					run = $urandom_range(1, 6);
				end else if (r < 85) begin
					out_stall <= 1'b1;
					run = $urandom_range(1, 3);
				end else if (r < 95) begin
					out_stall <= 1'b0;
					run = $urandom_range(40, 150);
				end else begin
					out_stall <= 1'b1;
					run = $urandom_range(10, 40);
				end
				repeat (run - 1) @(posedge clk);
			end
		end
	end

	// Offers one input beat and holds it until the block takes it. A gap after
	// the beat lowers valid; with no gap valid stays high for the next beat.
	task automatic send_beat(input logic signed [fevad_pkg::SAMPLE_W-1:0] s, input logic fe,
			input logic stp);
		int r;
		int gap;
		in_valid     <= 1'b1;
		sample       <= s;
		frame_end    <= fe;
		stop_request <= stp;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		items_sent++;
		gap = 0;
		if (!steady) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				gap = 0;
			else if (r < 85)
				gap = $urandom_range(1, 3);
			else if (r < 97)
				gap = $urandom_range(4, 12);
			else
				gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Frame lengths: mostly one to four samples, sometimes five to 24.
	function automatic int frame_len();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
	endfunction

	// Sends one frame whose level sits where the kind says. An edge frame uses a
	// constant magnitude of exactly the threshold or one below it, so its level
	// lands right on the boundary of the speech decision. Stop requests on the
	// inner samples are sprinkled in; the block must ignore them.
	task automatic send_frame(input frame_kind_t kind, input int len, input bit stop_at_end);
		int thr;
		int mag;
		bit below;
		logic signed [fevad_pkg::SAMPLE_W-1:0] s;
		thr   = int'(board.level_thr);
		below = ($urandom_range(0, 1) == 1);
		for (int i = 0; i < len; i++) begin
			case (kind)
				KIND_SILENT: mag = 0;
				KIND_QUIET:  mag = $urandom_range(0, (thr == 0) ? 0 : ((thr > 32768) ? 32767 : thr - 1));
				KIND_EDGE:   mag = (thr > 32768) ? 32768 : thr - ((below && thr > 0) ? 1 : 0);
				KIND_LOUD:   mag = $urandom_range((thr > 32767) ? 32767 : thr, 32767);
				default:     mag = -1;
			endcase
			if (mag < 0)
				s = fevad_pkg::SAMPLE_W'($urandom);
			else if (mag == 32768 || $urandom_range(0, 1))
				s = fevad_pkg::SAMPLE_W'(-mag);
			else
				s = fevad_pkg::SAMPLE_W'(mag);
			send_beat(s, i == len - 1, (i == len - 1) ? stop_at_end : ($urandom_range(0, 7) == 0));
		end
	endtask

	// A well-formed session: speech first, then about as many quiet frames as
	// the hangover needs to run out, sometimes one short of it so the session
	// carries on. Stray loud frames restart the silence timer.
	task automatic run_session();
		int need;
		int quiet;
		int step;
		int limit;
		int r;
		step  = int'(board.quiet_step_ms);
		limit = int'(board.hangover_ms);
		repeat ($urandom_range(1, 3))
			send_frame($urandom_range(0, 1) ? KIND_LOUD : KIND_EDGE, frame_len(), 1'b0);
		if (step == 0)
			need = $urandom_range(1, 6);
		else
			need = (limit + step - 1) / step;
		if (need < 1)
			need = 1;
		if (need > MAX_QUIET)
			need = MAX_QUIET;
		quiet = ($urandom_range(0, 3) == 0) ? need - 1 : need + $urandom_range(0, 1);
		repeat (quiet) begin
			r = $urandom_range(0, 9);
			send_frame((r == 0) ? KIND_LOUD : ((r < 3) ? KIND_SILENT : KIND_QUIET), frame_len(),
				$urandom_range(0, 24) == 0);
		end
	endtask

	// Mostly sessions, with some stand-alone frames of any kind mixed in.
	task automatic run_phase(input int budget);
		int stop_at;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 4) == 0)
				send_frame(frame_kind_t'($urandom_range(0, 4)), frame_len(), $urandom_range(0, 7) == 0);
			else
				run_session();
		end
	endtask

	// Writes one register. The write enable stays high for the caller to lower.
	task automatic put_reg(input logic [fevad_pkg::CFG_IDX_W-1:0] idx,
			input logic [fevad_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.write_reg(idx, data);
	endtask

	task automatic set_regs(input logic [fevad_pkg::CFG_DATA_W-1:0] thr,
			input logic [fevad_pkg::CFG_DATA_W-1:0] dur,
			input logic [fevad_pkg::CFG_DATA_W-1:0] tmo, input bit poke_spare);
		put_reg(fevad_pkg::REG_LEVEL_THRESHOLD, thr);
		put_reg(fevad_pkg::REG_FRAME_DURATION_MS, dur);
		put_reg(fevad_pkg::REG_SILENCE_TIMEOUT_MS, tmo);
		if (poke_spare)
			put_reg(REG_SPARE, fevad_pkg::CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Stops offering, waits for every owed verdict, then lets trailing sample
	// beats that cause no result clear the squaring path.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.open_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		board        = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		sample       = '0;
		frame_end    = 1'b0;
		stop_request = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset settings (threshold 200, 40 ms, 1500 ms).
		send_beat(16'sd0, 1'b1, 1'b0);          // silent single-sample frame
		send_beat(-16'sd32768, 1'b1, 1'b0);     // full scale negative, level 32768
		send_beat(16'sd32767, 1'b1, 1'b0);      // full scale positive
		send_beat(16'sd200, 1'b0, 1'b0);        // level exactly at the threshold
		send_beat(-16'sd200, 1'b1, 1'b0);
		send_beat(16'sd199, 1'b1, 1'b0);        // one below: silence timer starts
		send_beat(16'sd5, 1'b0, 1'b1);          // stop with no frame end is ignored
		send_beat(-16'sd5, 1'b1, 1'b0);
		send_beat(16'sd3, 1'b1, 1'b1);          // stop ends an active session
		send_beat(16'sd0, 1'b1, 1'b1);          // stop ends an idle session
		send_beat(16'sd1, 1'b0, 1'b0);
		send_beat(-16'sd1, 1'b1, 1'b0);
		send_beat(16'sh5555, 1'b0, 1'b0);       // alternating bit patterns
		send_beat(16'shAAAA, 1'b1, 1'b0);
		settle();

		// Zero timeout: the first quiet frame after speech ends the session, and
		// it wins over a stop request that comes with the same frame.
		set_regs(16'd300, 16'd500, 16'd0, 1'b0);
		send_beat(16'sd1000, 1'b1, 1'b0);
		send_beat(16'sd0, 1'b1, 1'b1);
		send_beat(16'sd0, 1'b1, 1'b0);

		// Random phases, each at its own register setting. The first runs the
		// sender with no gaps while the receiver holds off for a long stretch.
		for (int p = 0; p < 7; p++) begin
			settle();
			case (p)
				0: begin
					set_regs(16'd100, 16'd0, 16'd1, 1'b0);     // timer never advances
					steady       = 1'b1;
					hold_off_req = 1'b1;
				end
				1: set_regs(16'd300, 16'd500, 16'd0, 1'b0);
				2: set_regs(16'd0, 16'd1, 16'hFFFF, 1'b0);     // every frame is speech
				// Upper data bits of the duration write must be dropped.
				3: set_regs(16'd32768, 16'hFC00 | 16'd1023, 16'hFFFF, 1'b1);
				5: set_regs(16'hFFFF, 16'd1000, 16'd1, 1'b0);  // nothing is speech
				default: set_regs(fevad_pkg::CFG_DATA_W'($urandom_range(50, 3000)),
					fevad_pkg::CFG_DATA_W'($urandom_range(1, 1000)),
					fevad_pkg::CFG_DATA_W'($urandom_range(1, 5000)), p == 6);
			endcase
			run_phase(PHASE_ITEMS);
			steady = 1'b0;
		end

		// Full-scale noise frames back at the reset settings.
		settle();
		set_regs(fevad_pkg::THR_RESET, fevad_pkg::CFG_DATA_W'(fevad_pkg::DUR_RESET),
			fevad_pkg::TMO_RESET, 1'b0);
		send_frame(KIND_NOISE, 24, 1'b0);
		send_frame(KIND_NOISE, frame_len(), $urandom_range(0, 1) == 1);
		settle();

		if (board.errors == 0 && board.open_verdicts.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
src/fevad_pkg.sv
src/fevad_cmpsub.sv
src/fevad_root_engine.sv
src/frame_energy_voice_activity_detector.sv
sim/tb_frame_energy_voice_activity_detector.sv
